FILE: hw/rtl/mbs_pkg.sv
package mbs_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int TICK_BITS_DEF    = 32;

  localparam logic [2:0] REQ_NOTE_ON  = 3'd0;
  localparam logic [2:0] REQ_TIME_SIG = 3'd1;
  localparam logic [2:0] REQ_END_TRK  = 3'd2;
  localparam logic [2:0] REQ_END_IN   = 3'd4;

  localparam logic [2:0] CFG_QUARTER   = 3'd0;
  localparam logic [2:0] CFG_BARS      = 3'd1;
  localparam logic [2:0] CFG_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_FIRST_TK  = 3'd3;
  localparam logic [2:0] CFG_FIRST_FND = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_DIV,
    ST_INIT_MUL,
    ST_EVAL,
    ST_DIV,
    ST_RMW,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_STOPPED
  } state_t;

endpackage

FILE: hw/rtl/mbs_div.sv
module mbs_div #(
  parameter int W = mbs_pkg::TICK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output logic              busy,
  output logic [W-1:0]      quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/mbs_seg_mem.sv
module mbs_seg_mem #(
  parameter int DEPTH = mbs_pkg::MAX_SEGMENTS_DEF,
  parameter int W     = mbs_pkg::TICK_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [W-1:0]    wstart,
  input  logic [W-1:0]    wend,
  input  logic [15:0]     wcount,
  input  logic [AW-1:0]   raddr,
  output logic [W-1:0]    rstart,
  output logic [W-1:0]    rend,
  output logic [15:0]     rcount
);

  logic [W+W+15:0] mem [DEPTH];
  logic [W+W+15:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wstart, wend, wcount};
    rd_r <= mem[raddr];
  end

  assign rstart = rd_r[W+W+15:W+16];
  assign rend   = rd_r[W+15:16];
  assign rcount = rd_r[15:0];

endmodule

FILE: hw/rtl/midi_bar_segmenter.sv
// Operation: an accepted item occupies the block for the bit-serial tick / bar length
// divide; the first item first runs the first-bar divide and multiply. An event below
// the start offset is dropped without a divide.
// A finishing item scans the segment memory for the first segment with notes,
// then streams one segment per cycle while out_tready does not stall, one memory read each.
// Throughput: one item at a time. Reset (rst_n, synchronous, active low)
// restores registers to defaults and returns to the not-started state.
module midi_bar_segmenter #(
  parameter int MAX_SEGMENTS = mbs_pkg::MAX_SEGMENTS_DEF,
  parameter int TICK_BITS    = mbs_pkg::TICK_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0]
  input  logic [2:0]   in_tuser,
  // event_tick[31:0], velocity[38:32], sig_numerator[46:39],
  // sig_denominator_log[49:47], zero fill
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // segment_start[31:0], segment_end[63:32], end_open[64], notes_in_segment[80:65]
  output logic [87:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int W  = TICK_BITS;

  // configuration
  logic [14:0] quarter_r;
  logic [7:0]  bars_r;
  logic [6:0]  limit_r;
  logic [31:0] first_tick_r;
  logic        first_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quarter_r     <= 15'd96;
      bars_r        <= 8'd4;
      limit_r       <= 7'd64;
      first_tick_r  <= '0;
      first_found_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbs_pkg::CFG_QUARTER:   quarter_r     <= cfg_wdata[14:0];
        mbs_pkg::CFG_BARS:      bars_r        <= cfg_wdata[7:0];
        mbs_pkg::CFG_LIMIT:     limit_r       <= cfg_wdata[6:0];
        mbs_pkg::CFG_FIRST_TK:  first_tick_r  <= cfg_wdata;
        mbs_pkg::CFG_FIRST_FND: first_found_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [W-1:0] q4;
  logic [CW-1:0] lim;
  logic [7:0] bps;
  assign q4  = W'({(quarter_r == 15'd0) ? 15'd1 : quarter_r, 2'b00});
  assign bps = (bars_r == 8'd0) ? 8'd1 : bars_r;
  always_comb begin
    if (limit_r == 7'd0) lim = CW'(1);
    else if (32'(limit_r) > 32'(MAX_SEGMENTS)) lim = CW'(MAX_SEGMENTS);
    else lim = CW'(limit_r);
  end

  // state
  mbs_pkg::state_t state_r, state_nxt;
  logic          started_r, started_nxt;
  logic [W-1:0]  bar_ticks_r, bar_ticks_nxt;
  logic [W-1:0]  offset_r, offset_nxt;
  logic [W-1:0]  last_cut_r, last_cut_nxt;
  logic [CW-1:0] seg_idx_r, seg_idx_nxt;
  // current segment kept in registers, written back on cut / finish
  logic [W-1:0]  cur_start_r, cur_start_nxt;
  logic [15:0]   cur_count_r, cur_count_nxt;
  // item held
  logic [2:0]    typ_r, typ_nxt;
  logic [W-1:0]  tick_r, tick_nxt;
  logic          vel_nz_r, vel_nz_nxt;
  // emit walk
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          found_r, found_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [87:0]   odata_r, odata_nxt;
  logic          olast_r, olast_nxt;

  logic         div_start, div_busy;
  logic [W-1:0] div_a, div_b, div_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wstart, wend, rstart, rend;
  logic [15:0]   wcount, rcount;

  // time signature on the first item uses the bar length captured at accept
  logic [W-1:0] sig_len_r;
  logic [W-1:0] sig_len_held;

  mbs_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  mbs_seg_mem #(.DEPTH(MAX_SEGMENTS), .W(W), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wend(wend), .wcount(wcount),
    .raddr(raddr), .rstart(rstart), .rend(rend), .rcount(rcount)
  );

  logic [W+7:0] sig_prod;
  logic [W-1:0] sig_len;
  logic [W-1:0] diff;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] total_fin;

  assign sig_prod = (W+8)'(in_tdata[46:39]) * (W+8)'(q4);
  assign ptr_inc  = ptr_r + 1'b1;
  assign total_fin = ((seg_idx_r + 1'b1) > lim) ? lim : (seg_idx_r + 1'b1);
  assign diff = div_q - last_cut_r;

  always_comb begin
    sig_len = W'(sig_prod >> in_tdata[49:47]);
    if (sig_len == '0) sig_len = q4;
  end

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    bar_ticks_nxt = bar_ticks_r;
    offset_nxt    = offset_r;
    last_cut_nxt  = last_cut_r;
    seg_idx_nxt   = seg_idx_r;
    cur_start_nxt = cur_start_r;
    cur_count_nxt = cur_count_r;
    typ_nxt       = typ_r;
    tick_nxt      = tick_r;
    vel_nz_nxt    = vel_nz_r;
    ptr_nxt       = ptr_r;
    first_nxt     = first_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    ovalid_nxt    = ovalid_r;
    odata_nxt     = odata_r;
    olast_nxt     = olast_r;
    div_start     = 1'b0;
    div_a         = tick_r;
    div_b         = bar_ticks_r;
    we            = 1'b0;
    waddr         = seg_idx_r[AW-1:0];
    wstart        = cur_start_r;
    wend          = tick_r;
    wcount        = cur_count_r;
    raddr         = ptr_r[AW-1:0];
    in_tready     = 1'b0;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      mbs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          typ_nxt    = in_tuser;
          tick_nxt   = W'(in_tdata[31:0]);
          vel_nz_nxt = in_tdata[38:32] != 7'd0;
          if (!started_r) begin
            started_nxt   = 1'b1;
            bar_ticks_nxt = q4;
            seg_idx_nxt   = '0;
            cur_count_nxt = '0;
            div_start     = 1'b1;
            div_a         = first_found_r ? W'(first_tick_r) : '0;
            div_b         = q4;
            state_nxt     = mbs_pkg::ST_INIT_DIV;
          end else begin
            state_nxt = mbs_pkg::ST_EVAL;
          end
          if (in_tuser == mbs_pkg::REQ_TIME_SIG && started_r &&
              W'(in_tdata[31:0]) >= offset_r)
            bar_ticks_nxt = sig_len;
        end
      end
      mbs_pkg::ST_INIT_DIV: begin
        if (!div_busy) begin
          last_cut_nxt = div_q;
          state_nxt    = mbs_pkg::ST_INIT_MUL;
        end
      end
      mbs_pkg::ST_INIT_MUL: begin
        offset_nxt    = W'(last_cut_r * bar_ticks_r);
        cur_start_nxt = W'(last_cut_r * bar_ticks_r);
        state_nxt     = mbs_pkg::ST_EVAL;
        if (typ_r == mbs_pkg::REQ_TIME_SIG && tick_r >= W'(last_cut_r * bar_ticks_r))
          bar_ticks_nxt = sig_len_held;
      end
      mbs_pkg::ST_EVAL: begin
        if (typ_r == mbs_pkg::REQ_END_IN ||
            (typ_r == mbs_pkg::REQ_END_TRK && tick_r >= offset_r)) begin
          we        = 1'b1;
          ptr_nxt   = '0;
          total_nxt = total_fin;
          found_nxt = 1'b0;
          first_nxt = '0;
          state_nxt = mbs_pkg::ST_SCAN;
        end else if (tick_r < offset_r) begin
          state_nxt = mbs_pkg::ST_IDLE;
        end else begin
          if (typ_r == mbs_pkg::REQ_NOTE_ON && vel_nz_r && cur_count_r != 16'hFFFF)
            cur_count_nxt = cur_count_r + 1'b1;
          div_start = 1'b1;
          state_nxt = mbs_pkg::ST_DIV;
        end
      end
      mbs_pkg::ST_DIV: begin
        if (!div_busy) state_nxt = mbs_pkg::ST_RMW;
      end
      mbs_pkg::ST_RMW: begin
        if (diff >= W'(bps)) begin
          we          = 1'b1;
          seg_idx_nxt = seg_idx_r + 1'b1;
          if ((seg_idx_r + 1'b1) >= lim) begin
            ptr_nxt   = '0;
            first_nxt = '0;
            total_nxt = lim;
            state_nxt = mbs_pkg::ST_EMIT_RD;
          end else begin
            cur_start_nxt = tick_r;
            cur_count_nxt = '0;
            last_cut_nxt  = div_q;
            state_nxt     = mbs_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = mbs_pkg::ST_IDLE;
        end
      end
      mbs_pkg::ST_SCAN: begin
        // ptr_r-1 read data valid once ptr_r > 0
        if (ptr_r != '0 && !found_r && rcount != 16'd0) begin
          found_nxt = 1'b1;
          first_nxt = ptr_r - 1'b1;
        end
        if (ptr_r == total_r) begin
          ptr_nxt   = (found_r || rcount == 16'd0) ? first_r : ptr_r - 1'b1;
          if (!found_r && rcount != 16'd0) ptr_nxt = ptr_r - 1'b1;
          if (!found_r && rcount == 16'd0) ptr_nxt = '0;
          state_nxt = mbs_pkg::ST_EMIT_RD;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
      mbs_pkg::ST_EMIT_RD: begin
        state_nxt = mbs_pkg::ST_EMIT;
      end
      mbs_pkg::ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = ptr_inc == total_r;
          odata_nxt  = {7'd0, rcount, ptr_inc == total_r,
                        (ptr_inc == total_r) ? 32'hFFFF_FFFF : 32'(rend), 32'(rstart)};
          if (ptr_inc == total_r) begin
            state_nxt = mbs_pkg::ST_STOPPED;
          end else begin
            ptr_nxt   = ptr_inc;
            raddr     = ptr_inc[AW-1:0];
            state_nxt = mbs_pkg::ST_EMIT;
          end
        end
      end
      mbs_pkg::ST_STOPPED: begin
        in_tready = !ovalid_r;
      end
      default: state_nxt = mbs_pkg::ST_IDLE;
    endcase
  end

  assign sig_len_held = sig_len_r;
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) sig_len_r <= sig_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbs_pkg::ST_IDLE;
      started_r   <= 1'b0;
      bar_ticks_r <= W'(384);
      offset_r    <= '0;
      last_cut_r  <= '0;
      seg_idx_r   <= '0;
      ovalid_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      bar_ticks_r <= bar_ticks_nxt;
      offset_r    <= offset_nxt;
      last_cut_r  <= last_cut_nxt;
      seg_idx_r   <= seg_idx_nxt;
      ovalid_r    <= ovalid_nxt;
      found_r     <= found_nxt;
    end
    cur_start_r <= cur_start_nxt;
    cur_count_r <= cur_count_nxt;
    typ_r       <= typ_nxt;
    tick_r      <= tick_nxt;
    vel_nz_r    <= vel_nz_nxt;
    ptr_r       <= ptr_nxt;
    first_r     <= first_nxt;
    total_r     <= total_nxt;
    odata_r     <= odata_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

FILE: hw/rtl/mbs_checker.sv
module mbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_last_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[64] && out_tdata[63:32] == 32'hFFFF_FFFF)
    else $error("final segment not open-ended");

  a_open_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[64])
    else $error("open end on inner segment");

  a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !(in_tvalid && in_tready))
    else $error("input taken mid emit");

endmodule

bind midi_bar_segmenter mbs_checker u_mbs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
